### design/fbab_pkg.sv
`default_nettype none

package fbab_pkg;

    // pixel formats as held in the pixel_format register
    typedef enum logic [1:0] {
        FMT_RGB555   = 2'd0,
        FMT_RGB565   = 2'd1,
        FMT_RGB888   = 2'd2,
        FMT_XRGB8888 = 2'd3
    } t_pix_fmt;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

    // colour channel selectors
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam int unsigned NUM_CH  = 3;

    // default address width
    localparam int unsigned DEF_ADDR_BITS = 32;

    // channel masks of the formats
    localparam logic [31:0] MASK_R555 = 32'h1f << 10;
    localparam logic [31:0] MASK_G555 = 32'h1f << 5;
    localparam logic [31:0] MASK_R565 = 32'h1f << 11;
    localparam logic [31:0] MASK_G565 = 32'h3f << 5;
    localparam logic [31:0] MASK_B5   = 32'h1f;
    localparam logic [31:0] MASK_R888 = 32'hff << 16;
    localparam logic [31:0] MASK_G888 = 32'hff << 8;
    localparam logic [31:0] MASK_B888 = 32'hff;

    // stage advance enables shared by the datapath slices
    typedef struct packed {
        logic en2;
        logic en3;
    } t_pipe_en;

    function automatic logic [31:0] fmt_mask(input t_pix_fmt fmt, input logic [1:0] ch);
        logic [31:0] m;
        m = MASK_B888;
        case (fmt)
            FMT_RGB555: m = (ch == CH_RED) ? MASK_R555 : (ch == CH_GREEN) ? MASK_G555 : MASK_B5;
            FMT_RGB565: m = (ch == CH_RED) ? MASK_R565 : (ch == CH_GREEN) ? MASK_G565 : MASK_B5;
            default:    m = (ch == CH_RED) ? MASK_R888 : (ch == CH_GREEN) ? MASK_G888 : MASK_B888;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] fmt_shift(input t_pix_fmt fmt, input logic [1:0] ch);
        logic [4:0] s;
        s = 5'd0;
        case (fmt)
            FMT_RGB555: s = (ch == CH_RED) ? 5'd10 : (ch == CH_GREEN) ? 5'd5 : 5'd0;
            FMT_RGB565: s = (ch == CH_RED) ? 5'd11 : (ch == CH_GREEN) ? 5'd5 : 5'd0;
            default:    s = (ch == CH_RED) ? 5'd16 : (ch == CH_GREEN) ? 5'd8 : 5'd0;
        endcase
        return s;
    endfunction

    // bytes per pixel, 15 bpp rounded up to 2
    function automatic logic [2:0] fmt_bytes(input t_pix_fmt fmt);
        logic [2:0] b;
        b = 3'd4;
        case (fmt)
            FMT_RGB555:   b = 3'd2;
            FMT_RGB565:   b = 3'd2;
            FMT_RGB888:   b = 3'd3;
            FMT_XRGB8888: b = 3'd4;
            default:      b = 3'd4;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] unpack_chan(input t_pix_fmt fmt, input logic [1:0] ch,
                                               input logic [31:0] word);
        return 8'((word & fmt_mask(fmt, ch)) >> fmt_shift(fmt, ch));
    endfunction

    function automatic logic [31:0] pack_chan(input t_pix_fmt fmt, input logic [1:0] ch,
                                              input logic [7:0] v);
        return (32'(v) << fmt_shift(fmt, ch)) & fmt_mask(fmt, ch);
    endfunction

endpackage

`default_nettype wire

### design/fbab_mix.sv
`default_nettype none

// one colour channel of the blend, stages two and three
module fbab_mix
    import fbab_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_pipe_en i_en,
    input  wire logic [7:0] i_alpha,
    input  wire logic [7:0] i_top,
    input  wire logic [7:0] i_back,
    output logic [7:0]      o_mix
);

    logic [8:0]  w_fa;
    logic [8:0]  w_fb;
    logic [16:0] r_pt;
    logic [16:0] r_pb;
    logic [17:0] w_sum;
    logic [7:0]  r_mix;

    // weights a+1 and 256-a; alpha zero gives back unchanged through the same formula
    assign w_fa = {1'b0, i_alpha} + 9'd1;
    assign w_fb = 9'd256 - {1'b0, i_alpha};

    // stage two: weighted products
    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_pt <= {8'd0, w_fa} * {9'd0, i_top};
            r_pb <= {8'd0, w_fb} * {9'd0, i_back};
        end
    end

    // stage three: sum, divide by 256, keep 8 bits
    assign w_sum = {1'b0, r_pt} + {1'b0, r_pb};

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_mix <= w_sum[15:8];
        end
    end

    assign o_mix = r_mix;

endmodule

`default_nettype wire

### design/framebuffer_alpha_blend_pixel.sv
// Alpha blending pixel writer for a linear framebuffer.
// Slave stream (i_s_*) carries one pixel per transfer: position, the word
// already read from the framebuffer at that spot and the RGBA top colour.
// Master stream (o_m_*) returns the byte address to write and the blended
// word packed in the configured format; bits outside the colour masks are 0.
// The configuration channel (i_cfg_*) writes frame_base, line_pitch and
// pixel_format; it is always ready and should be used only while idle.
// A result passes through the unpack, multiply and add registers in that order
// before it is valid on o_m_tvalid. Throughput: one pixel per cycle while the
// receiver does not stall, set by the three register stages (unpack, multiply,
// add) each holding one item.
// Each stage advances when it is empty or the stage after it advances, so
// a stall of the receiver holds the results in place and bubbles collapse;
// o_s_tready drops only when all three stages are full and stalled.
// Synchronous reset empties the pipeline and sets frame_base 0,
// line_pitch 0 and pixel_format XRGB8888.
`default_nettype none

module framebuffer_alpha_blend_pixel
    import fbab_pkg::*;
#(
    parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [11:0] pos_x, [23:12] pos_y, [55:24] dest_word, [63:56] top_red,
    // [71:64] top_green, [79:72] top_blue, [87:80] top_alpha
    input  wire logic [87:0] i_s_tdata,
    // write output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [31:0] pixel_address, [63:32] pixel_word
    output logic [63:0]      o_m_tdata,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    // configuration registers
    logic [31:0] r_base;
    logic [15:0] r_pitch;
    t_pix_fmt    r_fmt;

    // stage valids and enables
    logic     r_v1, r_v2, r_v3;
    logic     w_en1;
    t_pipe_en w_en;

    // stage one
    logic [11:0] r_x1;
    logic [11:0] r_y1;
    t_pix_fmt    r_fmt1;
    logic [7:0]  r_a1;
    logic [7:0]  r_top1  [NUM_CH];
    logic [7:0]  r_back1 [NUM_CH];

    // stage two
    logic [27:0] r_yp2;
    logic [13:0] r_xb2;
    t_pix_fmt    r_fmt2;

    // stage three
    logic [ADDR_BITS-1:0] r_addr3;
    t_pix_fmt             r_fmt3;
    logic [7:0]           w_mix3 [NUM_CH];
    logic [31:0]          w_word;

    logic [31:0] w_dest;

    assign o_cfg_ready = 1'b1;

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 32'd0;
            r_pitch <= 16'd0;
            r_fmt   <= FMT_XRGB8888;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FRAME_BASE:   r_base  <= i_cfg_data;
                REG_LINE_PITCH:   r_pitch <= i_cfg_data[15:0];
                REG_PIXEL_FORMAT: r_fmt   <= t_pix_fmt'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // stage advance chain from the output backwards
    assign w_en.en3   = !r_v3 || i_m_tready;
    assign w_en.en2   = !r_v2 || w_en.en3;
    assign w_en1      = !r_v1 || w_en.en2;
    assign o_s_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1)    r_v1 <= i_s_tvalid;
            if (w_en.en2) r_v2 <= r_v1;
            if (w_en.en3) r_v3 <= r_v2;
        end
    end

    assign w_dest = i_s_tdata[55:24];

    // stage one: capture and unpack the destination channels
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_x1   <= i_s_tdata[11:0];
            r_y1   <= i_s_tdata[23:12];
            r_fmt1 <= r_fmt;
            r_a1   <= i_s_tdata[87:80];
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        always_ff @(posedge i_clk) begin
            if (w_en1) begin
                r_top1[c]  <= i_s_tdata[56+8*c +: 8];
                r_back1[c] <= unpack_chan(r_fmt, 2'(c), w_dest);
            end
        end

        fbab_mix u_mix (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_alpha (r_a1),
            .i_top   (r_top1[c]),
            .i_back  (r_back1[c]),
            .o_mix   (w_mix3[c])
        );
    end

    // stage two: address products
    always_ff @(posedge i_clk) begin
        if (w_en.en2) begin
            r_yp2  <= {16'd0, r_y1} * {12'd0, r_pitch};
            r_xb2  <= {2'd0, r_x1} * {11'd0, fmt_bytes(r_fmt1)};
            r_fmt2 <= r_fmt1;
        end
    end

    // stage three: address sum wrapping at the address width
    always_ff @(posedge i_clk) begin
        if (w_en.en3) begin
            r_addr3 <= ADDR_BITS'(r_base) + ADDR_BITS'(r_yp2) + ADDR_BITS'(r_xb2);
            r_fmt3  <= r_fmt2;
        end
    end

    // repack into the pixel format
    assign w_word = pack_chan(r_fmt3, CH_RED,   w_mix3[0])
                  | pack_chan(r_fmt3, CH_GREEN, w_mix3[1])
                  | pack_chan(r_fmt3, CH_BLUE,  w_mix3[2]);

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {w_word, 32'(r_addr3)};

    // an empty output stage always lets a new pixel in
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> o_s_tready)
        else $error("input stalled with empty output stage");

    // a blocked stage one item stays in place
    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !w_en.en2 |=> r_v1 && $stable(r_x1) && $stable(r_y1))
        else $error("stage one item lost during stall");

    // a blocked stage two item stays in place
    a_hold_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_en.en3 |=> r_v2 && $stable(r_yp2) && $stable(r_xb2))
        else $error("stage two item lost during stall");

    // no format uses the top byte of the word
    a_top_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (w_word[31:24] == 8'd0))
        else $error("pixel word has bits beyond the colour masks");

endmodule

`default_nettype wire
